[src/soundex_encoder_defines.svh]
// Assertion macros for the soundex encoder.
`ifndef SOUNDEX_ENCODER_DEFINES_SVH
`define SOUNDEX_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// Check prop at every rising clock edge, skipped while reset is asserted.
`define SDX_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("soundex_encoder: assertion failed");

// Check prop at every rising clock edge, reset included.
`define SDX_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("soundex_encoder: assertion failed");

`else

`define SDX_ASSERT(label, clk, rst_n, prop)
`define SDX_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[src/sdx_pkg.sv]
package sdx_pkg;

    typedef logic [2:0] sdx_code_t;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // Soundex digit group of one character; anything uncoded is zero.
    function automatic sdx_code_t code_of(input logic [7:0] ch);
        sdx_code_t c;
        case (ch) inside
            "B", "F", "P", "V":                     c = 3'd1;
            "C", "G", "J", "K", "Q", "S", "X", "Z": c = 3'd2;
            "D", "T":                               c = 3'd3;
            "L":                                    c = 3'd4;
            "M", "N":                               c = 3'd5;
            "R":                                    c = 3'd6;
            default:                                c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

[src/soundex_encoder.sv]
// Soundex encoder: takes a name one character per beat on the s_ stream,
// with s_tlast on its final character, and streams its Soundex code of
// CODE_LENGTH characters on the m_ stream: the first character unchanged,
// then digits '1' to '6' (a digit is dropped when it repeats the code of
// the character just before it, or once the code is full), padded with '0'
// after the final character; m_tlast marks the last character of the code.
// Rate: one input beat per cycle while m_tready is high. Only padding costs
// extra: after a final character that leaves the code short, the input holds
// while the pad digits (CODE_LENGTH - emitted count, at most CODE_LENGTH - 1)
// go out, since the single output register takes one code character per cycle.
// A code character passes through an input register, the coding logic, then
// the output register before it is presented on m_.
`include "soundex_encoder_defines.svh"

module soundex_encoder
    import sdx_pkg::*;
#(
    parameter int CODE_LENGTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] letter
    input  logic       s_tlast,   // name_end

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] code_char
    output logic       m_tlast    // code_end
);

    localparam int CNT_W = $clog2(CODE_LENGTH + 1);
    localparam logic [CNT_W-1:0] CODE_FULL_C = CNT_W'(CODE_LENGTH);

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_letter_reg;
    logic       in_last_reg;

    // Name state
    logic             at_start_reg, at_start_next;
    sdx_code_t        prev_code_reg, prev_code_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pad_reg, pad_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       out_end_reg, out_end_next;

    logic             out_free;
    logic             consume;
    logic             out_load;
    logic             pad_done;
    sdx_code_t        code;
    logic             emit;
    logic [7:0]       emit_char;
    logic [CNT_W-1:0] count_emit;
    logic [CNT_W-1:0] count_inc;

    // The output register can take a character when empty or draining now.
    assign out_free  = !out_valid_reg || m_tready;
    // Hold the buffered character while padding the previous name.
    assign consume   = in_valid_reg && out_free && !pad_reg;
    assign s_tready  = !in_valid_reg || consume;

    assign count_inc = count_reg + CNT_W'(1);
    assign pad_done  = pad_reg && out_free && (count_inc == CODE_FULL_C);

    // Code the buffered character against the state of its name.
    always_comb begin
        code       = code_of(in_letter_reg);
        emit       = at_start_reg ||
                     ((count_reg < CODE_FULL_C) && (code != 3'd0) && (code != prev_code_reg));
        emit_char  = at_start_reg ? in_letter_reg : (ASCII_ZERO + {5'd0, code});
        count_emit = emit ? count_inc : count_reg;
    end

    always_comb begin
        in_valid_next  = in_valid_reg;
        at_start_next  = at_start_reg;
        prev_code_next = prev_code_reg;
        count_next     = count_reg;
        pad_next       = pad_reg;
        out_load       = 1'b0;
        out_char_next  = out_char_reg;
        out_end_next   = out_end_reg;

        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end

        if (pad_reg) begin
            if (out_free) begin
                // Emit one pad digit; return to the start state on the last one.
                out_load      = 1'b1;
                out_char_next = ASCII_ZERO;
                out_end_next  = (count_inc == CODE_FULL_C);
                if (count_inc == CODE_FULL_C) begin
                    pad_next       = 1'b0;
                    at_start_next  = 1'b1;
                    prev_code_next = 3'd0;
                    count_next     = '0;
                end else begin
                    count_next = count_inc;
                end
            end
        end else if (consume) begin
            out_load       = emit;
            out_char_next  = emit_char;
            out_end_next   = (count_emit == CODE_FULL_C);
            at_start_next  = 1'b0;
            prev_code_next = code;
            count_next     = count_emit;
            if (in_last_reg) begin
                if (count_emit < CODE_FULL_C) begin
                    pad_next = 1'b1;
                end else begin
                    at_start_next  = 1'b1;
                    prev_code_next = 3'd0;
                    count_next     = '0;
                end
            end
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            at_start_reg  <= 1'b1;
            prev_code_reg <= 3'd0;
            count_reg     <= '0;
            pad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            at_start_reg  <= at_start_next;
            prev_code_reg <= prev_code_next;
            count_reg     <= count_next;
            pad_reg       <= pad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on a taken input beat or an output load, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_letter_reg <= s_tdata;
            in_last_reg   <= s_tlast;
        end
        if (out_load) begin
            out_char_reg <= out_char_next;
            out_end_reg  <= out_end_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_end_reg;

    // The emitted count never passes the code length.
    `SDX_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CODE_FULL_C)
    // Padding only follows a name whose first character was taken.
    `SDX_ASSERT(a_pad_not_start, aclk, aresetn, pad_reg |-> !at_start_reg)
    // The last pad digit returns the block to the start of a name.
    `SDX_ASSERT(a_pad_done_restart, aclk, aresetn,
        pad_done |=> (at_start_reg && !pad_reg && (count_reg == '0)))
    // While padding, the buffered character is never consumed.
    `SDX_ASSERT(a_pad_holds_input, aclk, aresetn,
        (pad_reg && in_valid_reg) |=> in_valid_reg)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
    import sdx_pkg::*;
();

    localparam int CODE_CHARS   = 4;
    localparam int RANDOM_CHARS = 280;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_CAP    = 30;

    // Soundex digit of 'A'..'Z', one ASCII digit per letter, 'A' in the top byte.
    localparam logic [8*26-1:0] LETTER_DIGITS = "01230120022455012623010202";

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } code_beat_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE,
        RX_PULSE
    } rx_mode_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] letter
    logic       s_tlast  = 1'b0;    // name_end
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] code_char
    logic       m_tlast;            // code_end

    // Predictor state: one name in flight at a time.
    logic       mid_name   = 1'b0;
    sdx_code_t  prev_group = '0;
    int         chars_out  = 0;

    code_beat_t pending_codes[$];
    code_beat_t want;

    int error_count    = 0;
    int chars_sent     = 0;
    int names_finished = 0;
    int codes_checked  = 0;
    int burst_left     = 0;
    int cycle_count    = 0;

    rx_mode_t   rx_mode    = RX_FREE;
    int         rx_left    = 0;

    soundex_encoder #(
        .CODE_LENGTH(CODE_CHARS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #6 aclk = ~aclk;

    // Hard stop: the slowest correct run is far below this.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver backpressure: switch at random between stall styles, free-running
    // stretches included.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
            RX_PULSE:  m_tready <= (cycle_count % 7) < 3;
            default:   m_tready <= 1'b1;
        endcase
    end

    // Soundex group of one byte; anything but an upper-case letter is uncoded.
    function automatic sdx_code_t letter_group(input logic [7:0] ch);
        int idx;
        if (ch < "A" || ch > "Z") begin
            return '0;
        end
        idx = ch - "A";
        return sdx_code_t'(LETTER_DIGITS[8*(25-idx) +: 8] - "0");
    endfunction

    function automatic void push_code(input logic [7:0] ch);
        code_beat_t beat;
        chars_out++;
        beat.ch  = ch;
        beat.fin = (chars_out >= CODE_CHARS);
        pending_codes.push_back(beat);
    endfunction

    // Work out the code characters one accepted input beat must produce.
    function automatic void predict_code(input logic [7:0] ch, input logic fin);
        sdx_code_t grp;
        grp = letter_group(ch);
        if (!mid_name) begin
            // first character passes through unchanged
            chars_out = 0;
            push_code(ch);
            mid_name = 1'b1;
        end else if (chars_out < CODE_CHARS) begin
            // drop uncoded characters and repeats of the previous group
            if (grp != '0 && grp != prev_group) begin
                push_code(ASCII_ZERO + 8'(grp));
            end
        end
        prev_group = grp;
        if (fin) begin
            // pad a short code with '0', then start over for the next name
            while (chars_out < CODE_CHARS) begin
                push_code(ASCII_ZERO);
            end
            mid_name   = 1'b0;
            prev_group = '0;
            chars_out  = 0;
            names_finished++;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        error_count++;
    endtask

    // Compare every accepted code beat with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            codes_checked++;
            if (pending_codes.size() == 0) begin
                report_mismatch($sformatf("unexpected code beat %h/%b", m_tdata, m_tlast));
            end else begin
                want = pending_codes.pop_front();
                if (m_tdata !== want.ch) begin
                    report_mismatch($sformatf("code_char %h, predicted %h", m_tdata, want.ch));
                end
                if (m_tlast !== want.fin) begin
                    report_mismatch($sformatf("code_end %b, predicted %b", m_tlast, want.fin));
                end
            end
        end
    end

    // Send one character beat; hold valid into the next beat unless a burst ends in an idle gap.
    task automatic send_char(input logic [7:0] ch, input logic fin);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predict_code(ch, fin);
        chars_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_name(input string name);
        for (int k = 0; k < name.len(); k++) begin
            send_char(name[k], k == name.len() - 1);
        end
    endtask

    // Every digit group, each after an uncoded first letter.
    task automatic test_code_groups();
        send_name("ABDL");
        send_name("EMRC");
    endtask

    // One-character names pad out to the full length; byte extremes pass through.
    task automatic test_single_char();
        send_name("Z");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    // Same group right after the first letter is dropped; H between repeats
    // separates them.
    task automatic test_repeats();
        send_name("PFB");
        send_name("BHB");
    endtask

    // Code fills up before the name ends; the lower-case letter and the
    // non-letter final emit nothing.
    task automatic test_full_early();
        send_char("R", 1'b0);
        send_char("u", 1'b0);
        send_char("P", 1'b0);
        send_char("E", 1'b0);
        send_char("R", 1'b0);
        send_char("T", 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    // Mostly upper-case names with frequent repeated letters, some raw byte noise.
    task automatic test_random_names();
        int         start;
        int         len;
        logic [7:0] ch;
        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS) begin
            if ($urandom_range(0, 9) < 8) begin
                len = $urandom_range(1, 10);
                ch  = 8'("A" + $urandom_range(0, 25));
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 3) != 0) begin
                        ch = 8'("A" + $urandom_range(0, 25));
                    end
                    send_char(ch, k == len - 1);
                end
            end else begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    send_char(8'($urandom_range(0, 255)),
                              ($urandom_range(0, 2) == 0) || (k == len - 1));
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_code_groups();
        test_single_char();
        test_repeats();
        test_full_early();
        test_random_names();

        // drain: idle the input, wait for the last predictions, then watch for strays
        s_tvalid <= 1'b0;
        while (pending_codes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d names, %0d input beats, %0d code beats checked",
                 names_finished, chars_sent, codes_checked);
        $display("summary: all digit groups, one-char names, early-full codes, byte noise");
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/sdx_pkg.sv
src/soundex_encoder.sv
tb/tb_top.sv
